/* rtl/preemptive_priority_scheduler_unit_assert.svh */
// Assertion macros shared by the scheduler's RTL.
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pps_pkg.sv */
// Shared constants and controller/datapath interface types for the scheduler.
package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int ARR_W   = 12;
  localparam int BUR_W   = 8;
  localparam int PRI_W   = 8;
  localparam int IDX_O_W = 4;
  localparam int TICK_W  = 13;
  localparam int SUM_W   = 17;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store an incoming record if there is room
    logic scan_clear;  // restart the search over the job slots
    logic rd_scan;     // read the slot under the scan pointer
    logic eval;        // compare the read slot against the best so far
    logic tick_idle;   // no job was ready: advance time only
    logic rd_best;     // read the winning slot
    logic tick_run;    // serve the winner for one tick
    logic finish;      // the winner completed: issue its result
    logic clear;       // the whole set completed: return to empty
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;   // the scan pointer sits on the last loaded slot
    logic best_valid;  // at least one ready job was found this tick
    logic run_done;    // the winner has one tick of service left
    logic last_done;   // the next completion is the last of the set
  } dp_sts_t;

endpackage

/* rtl/pps_ctrl.sv */
// Controller state machine that sequences loading, the per-tick search and completions.
module pps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_job,
  output logic              busy,
  output pps_pkg::dp_cmd_t  cmd,
  input  pps_pkg::dp_sts_t  sts
);
  import pps_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_RD = 3'd1;
  localparam logic [2:0] S_SCAN_EV = 3'd2;
  localparam logic [2:0] S_DECIDE  = 3'd3;
  localparam logic [2:0] S_RUN     = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_job) begin
            cmd.scan_clear = 1'b1;
            state_next     = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd.eval   = 1'b1;
        state_next = sts.scan_last ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        if (sts.best_valid) begin
          cmd.rd_best = 1'b1;
          state_next  = S_RUN;
        end else begin
          cmd.tick_idle  = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN_RD;
        end
      end
      S_RUN: begin
        cmd.tick_run = 1'b1;
        if (sts.run_done) begin
          state_next = S_FIN;
        end else begin
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN_RD;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        if (sts.last_done) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.scan_clear = 1'b1;
          state_next     = S_SCAN_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/pps_dp.sv */
// Datapath: job record memories, the search registers, the tick counter and the result register.
module pps_dp #(
  parameter int MaxProcs = pps_pkg::MAX_PROCS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pps_pkg::dp_cmd_t            cmd,
  output pps_pkg::dp_sts_t            sts,
  input  logic [pps_pkg::ARR_W-1:0]   arrival_time,
  input  logic [pps_pkg::BUR_W-1:0]   burst_length,
  input  logic [pps_pkg::PRI_W-1:0]   job_priority,
  output logic                        result_valid,
  output logic [pps_pkg::IDX_O_W-1:0] job_index,
  output logic [pps_pkg::TICK_W-1:0]  completion_time,
  output logic [pps_pkg::TICK_W-1:0]  turnaround_time,
  output logic [pps_pkg::TICK_W-1:0]  waiting_time,
  output logic [pps_pkg::SUM_W-1:0]   total_turnaround,
  output logic [pps_pkg::SUM_W-1:0]   total_waiting,
  output logic                        final_result
);
  import pps_pkg::*;

  localparam int IDX_W = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int CNT_W = $clog2(MaxProcs + 1);

  // Job record memories: one shared read address, registered read data.
  logic [ARR_W-1:0] arr_mem [MaxProcs];
  logic [BUR_W-1:0] bur_mem [MaxProcs];
  logic [PRI_W-1:0] pri_mem [MaxProcs];
  logic [BUR_W-1:0] rem_mem [MaxProcs];
  logic [MaxProcs-1:0] fin_flags;

  logic [ARR_W-1:0] rd_arr;
  logic [BUR_W-1:0] rd_bur;
  logic [PRI_W-1:0] rd_pri;
  logic [BUR_W-1:0] rd_rem;
  logic             rd_fin;

  logic [CNT_W-1:0]  job_count;
  logic [CNT_W-1:0]  done_count;
  logic [TICK_W-1:0] cur_tick;
  logic [SUM_W-1:0]  tat_sum;
  logic [SUM_W-1:0]  wt_sum;
  logic [TICK_W-1:0] tat_reg;

  logic [IDX_W-1:0] scan_idx;
  logic             best_valid;
  logic [IDX_W-1:0] best_idx;
  logic [PRI_W-1:0] best_pri;
  logic [ARR_W-1:0] best_arr;

  logic             full;
  logic             load_en;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             ready;
  logic             take;
  logic [TICK_W-1:0] wt_calc;
  logic [SUM_W-1:0]  tat_sum_next;
  logic [SUM_W-1:0]  wt_sum_next;
  logic [IDX_W+IDX_O_W-1:0] idx_ext;

  assign full    = (job_count == CNT_W'(MaxProcs));
  assign load_en = cmd.load && !full;
  assign rd_addr = cmd.rd_best ? best_idx : scan_idx;
  assign wr_addr = cmd.tick_run ? best_idx : job_count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (load_en) begin
      arr_mem[wr_addr] <= arrival_time;
      bur_mem[wr_addr] <= burst_length;
      pri_mem[wr_addr] <= job_priority;
    end
    if (load_en || cmd.tick_run) begin
      rem_mem[wr_addr] <= cmd.tick_run ? rd_rem - BUR_W'(1) : burst_length;
    end
    if (cmd.rd_scan || cmd.rd_best) begin
      rd_arr <= arr_mem[rd_addr];
      rd_bur <= bur_mem[rd_addr];
      rd_pri <= pri_mem[rd_addr];
      rd_rem <= rem_mem[rd_addr];
      rd_fin <= fin_flags[rd_addr];
    end
  end

  // A slot is eligible once it has arrived and is unfinished; ties go to the
  // strictly earlier arrival, then to the lower slot, which the scan order gives.
  assign ready = !rd_fin && ({1'b0, rd_arr} <= cur_tick);
  assign take  = !best_valid || (rd_pri < best_pri) ||
                 ((rd_pri == best_pri) && (rd_arr < best_arr));

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_idx <= '0;
    end else if (cmd.eval) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (cmd.eval && ready && take) begin
      best_idx <= scan_idx;
      best_pri <= rd_pri;
      best_arr <= rd_arr;
    end
    if (cmd.tick_run) begin
      tat_reg <= cur_tick + TICK_W'(1) - TICK_W'(rd_arr);
    end
  end

  assign wt_calc      = tat_reg - TICK_W'(rd_bur);
  assign tat_sum_next = tat_sum + SUM_W'(tat_reg);
  assign wt_sum_next  = wt_sum + SUM_W'(wt_calc);
  assign idx_ext      = {{IDX_O_W{1'b0}}, best_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count  <= '0;
      done_count <= '0;
      cur_tick   <= '0;
      tat_sum    <= '0;
      wt_sum     <= '0;
      fin_flags  <= '0;
      best_valid <= 1'b0;
    end else begin
      if (cmd.scan_clear) begin
        best_valid <= 1'b0;
      end else if (cmd.eval && ready) begin
        best_valid <= 1'b1;
      end
      if (cmd.tick_idle || cmd.tick_run) begin
        cur_tick <= cur_tick + TICK_W'(1);
      end
      if (load_en) begin
        job_count <= job_count + CNT_W'(1);
        fin_flags[job_count[IDX_W-1:0]] <= 1'b0;
      end
      if (cmd.clear) begin
        job_count  <= '0;
        done_count <= '0;
        cur_tick   <= '0;
        tat_sum    <= '0;
        wt_sum     <= '0;
        fin_flags  <= '0;
      end else if (cmd.finish) begin
        done_count          <= done_count + CNT_W'(1);
        tat_sum             <= tat_sum_next;
        wt_sum              <= wt_sum_next;
        fin_flags[best_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.finish;
    end
    if (cmd.finish) begin
      job_index        <= idx_ext[IDX_O_W-1:0];
      completion_time  <= cur_tick;
      turnaround_time  <= tat_reg;
      waiting_time     <= wt_calc;
      total_turnaround <= tat_sum_next;
      total_waiting    <= wt_sum_next;
      final_result     <= sts.last_done;
    end
  end

  assign sts.scan_last  = ((CNT_W'(scan_idx) + CNT_W'(1)) == job_count);
  assign sts.best_valid = best_valid;
  assign sts.run_done   = (rd_rem == BUR_W'(1));
  assign sts.last_done  = ((done_count + CNT_W'(1)) == job_count);

endmodule

/* rtl/preemptive_priority_scheduler_unit.sv */
// Top level of the preemptive priority scheduler: controller, datapath and checks.
//
// Job records are loaded one beat per cycle while busy is low: a beat is taken
// at each rising edge with start high and busy low, into slots 0, 1, 2 and so
// on. A record that comes when MaxProcs jobs are already held is dropped. The
// beat with last_job high starts the schedule and busy rises on the next cycle;
// no beat is taken until the last job of the set has completed. Time then runs
// in unit ticks from zero. Each tick the controller walks every loaded slot
// through the single read port of the record memories, a read step and an
// evaluate step per slot, then decides: an idle tick only advances time, and a
// served tick adds a run step, plus a finish step when the job completes. Each
// completion is presented on the result ports for exactly one cycle, marked by
// result_valid, and there is no back-pressure: the receiver must take every
// result beat as it comes. Strobes are never on two adjacent cycles. The beat
// carrying final_result high is the last of the set; busy is already low in
// that cycle, the tick counter and both running totals are back to zero, and
// a new set of jobs may be loaded straight away. A burst of zero is served for
// 256 ticks. There is no clearing pass after reset.
module preemptive_priority_scheduler_unit #(
  parameter int MaxProcs = pps_pkg::MAX_PROCS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pps_pkg::ARR_W-1:0]   arrival_time,
  input  logic [pps_pkg::BUR_W-1:0]   burst_length,
  input  logic [pps_pkg::PRI_W-1:0]   job_priority,
  input  logic                        last_job,
  output logic                        result_valid,
  output logic [pps_pkg::IDX_O_W-1:0] job_index,
  output logic [pps_pkg::TICK_W-1:0]  completion_time,
  output logic [pps_pkg::TICK_W-1:0]  turnaround_time,
  output logic [pps_pkg::TICK_W-1:0]  waiting_time,
  output logic [pps_pkg::SUM_W-1:0]   total_turnaround,
  output logic [pps_pkg::SUM_W-1:0]   total_waiting,
  output logic                        final_result
);
  import pps_pkg::*;

`include "preemptive_priority_scheduler_unit_assert.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sees only the start strobe, the last-job flag and the
  // datapath status; all payload stays in the datapath.
  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .last_job (last_job),
    .busy     (busy),
    .cmd      (cmd),
    .sts      (sts)
  );

  pps_dp #(
    .MaxProcs (MaxProcs)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .arrival_time     (arrival_time),
    .burst_length     (burst_length),
    .job_priority     (job_priority),
    .result_valid     (result_valid),
    .job_index        (job_index),
    .completion_time  (completion_time),
    .turnaround_time  (turnaround_time),
    .waiting_time     (waiting_time),
    .total_turnaround (total_turnaround),
    .total_waiting    (total_waiting),
    .final_result     (final_result)
  );

  // The final-job beat always starts a schedule.
  `PPS_ASSERT_NEXT(a_last_starts, clk, rst, start && !busy && last_job, busy, "schedule did not start")

  // The block is idle again exactly when the final result of a set appears.
  `PPS_ASSERT_NOW(a_final_idle, clk, rst, result_valid && final_result, !busy, "busy after final result")
  `PPS_ASSERT_NOW(a_mid_busy, clk, rst, result_valid && !final_result, busy, "idle before final result")

  // Each completion needs at least a fresh scan, so strobes never touch.
  `PPS_ASSERT_NEXT(a_strobe_gap, clk, rst, result_valid, !result_valid, "back-to-back result strobes")

endmodule
